FILE: hdl/plid_pkg.sv
// Shared types and constants for the positional list core.
// No dependencies; every other file imports this package.
`default_nettype none

package plid_pkg;

    // Command codes
    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_END   = 3'd1;
    localparam logic [2:0] CMD_INS_AT    = 3'd2;
    localparam logic [2:0] CMD_REM_FRONT = 3'd3;
    localparam logic [2:0] CMD_REM_END   = 3'd4;
    localparam logic [2:0] CMD_REM_AT    = 3'd5;
    localparam logic [2:0] CMD_READ      = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 9;
    localparam int CNT_W     = 9;
    localparam int MAX_IDX_W = 12;   // index bits for the largest list

    // Per-cycle control broadcast along the cell row
    typedef struct packed {
        logic                 ins;
        logic                 rem;
        logic                 rd;
        logic [MAX_IDX_W-1:0] at;
    } plid_shift_t;

endpackage

`default_nettype wire

FILE: hdl/plid_req_if.sv
// Request channel: valid/ready handshake with command, position and value.
// Depends on plid_pkg.
`default_nettype none

interface plid_req_if;
    import plid_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [2:0]               cmd;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, cmd, position, value, input ready);
    modport sink   (input valid, cmd, position, value, output ready);
endinterface

`default_nettype wire

FILE: hdl/plid_rsp_if.sv
// Result channel: valid/ready handshake with status, count and read value.
// Depends on plid_pkg.
`default_nettype none

interface plid_rsp_if;
    import plid_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] read_value;

    modport source (output valid, status, count, read_value, input ready);
    modport sink   (input valid, status, count, read_value, output ready);
endinterface

`default_nettype wire

FILE: hdl/plid_cell.sv
// One list entry: holds a value and shifts it to or from its neighbors.
// Depends on plid_pkg.
`default_nettype none

module plid_cell #(
    parameter int IDX = 0
) (
    input  wire                              clk,
    input  wire plid_pkg::plid_shift_t       shift,
    input  wire logic signed [31:0]          left_data,
    input  wire logic signed [31:0]          right_data,
    input  wire logic signed [31:0]          new_data,
    output logic signed [31:0]               data,
    output logic signed [31:0]               sel_data
);
    import plid_pkg::*;

    localparam logic [MAX_IDX_W-1:0] MY_IDX = MAX_IDX_W'(IDX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     hit;
    logic                     above;

    assign hit   = (shift.at == MY_IDX);
    assign above = (MY_IDX > shift.at);

    always_comb
    begin
        data_next = data_reg;
        if (shift.ins)
        begin
            if (above)
                data_next = left_data;
            else if (hit)
                data_next = new_data;
        end
        else if (shift.rem)
        begin
            if (above || hit)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign sel_data = (shift.rd && hit) ? data_reg : '0;

endmodule

`default_nettype wire

FILE: hdl/positional_list_insert_delete_core.sv
// Top level of the positional list core: command decode, cell row and
// two-level registered read gather. Depends on plid_pkg, plid_req_if,
// plid_rsp_if and plid_cell.
`default_nettype none

// Positional list of up to DEPTH signed 32-bit entries held in a row of
// cells; an insert or remove moves every affected entry one place in the
// same clock edge, so any command finishes its list work at that edge.
// A request is taken every cycle while results are drained; a result is
// registered first in stage 1, where the cells update and the selected
// entry is ORed within groups of 16, then in the output register, where
// the groups are combined. The output register lets the next request be
// taken while a result waits. No clearing pass after reset: entries at or
// above the count are never read.
module positional_list_insert_delete_core #(
    parameter int DEPTH = 256
) (
    input  wire        clk,
    input  wire        rst_n,
    plid_req_if.sink   request,
    plid_rsp_if.source result
);
    import plid_pkg::*;

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PW  = (CW > POS_W) ? CW : POS_W;
    localparam int GS  = 16;
    localparam int NG  = (DEPTH + GS - 1) / GS;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [CW-1:0]            cnt_reg;
    logic [CW-1:0]            cnt_next;
    logic                     s1_valid_reg;
    logic [1:0]               s1_status_reg;
    logic [CNT_W-1:0]         s1_count_reg;
    logic signed [DATA_W-1:0] grp_reg [NG];
    logic signed [DATA_W-1:0] grp_or  [NG];
    logic                     out_valid_reg;
    logic [1:0]               out_status_reg;
    logic [CNT_W-1:0]         out_count_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic signed [DATA_W-1:0] gather;

    logic                     accept;
    logic                     move;
    logic [1:0]               status;
    logic [PW-1:0]            pos_x;
    logic [PW-1:0]            cnt_x;
    logic [PW-1:0]            at_x;
    logic                     do_ins;
    logic                     do_rem;
    logic                     do_rd;
    plid_shift_t              shift;

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic signed [DATA_W-1:0] cell_sel  [DEPTH];

    assign move          = s1_valid_reg && (!out_valid_reg || result.ready);
    assign request.ready = !s1_valid_reg || move;
    assign accept        = request.valid && request.ready;

    assign pos_x = PW'(request.position);
    assign cnt_x = PW'(cnt_reg);

    always_comb
    begin
        status = ST_OK;
        at_x   = '0;
        do_ins = 1'b0;
        do_rem = 1'b0;
        do_rd  = 1'b0;
        unique case (request.cmd) inside
            CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT:
            begin
                if (request.cmd == CMD_INS_AT && pos_x > cnt_x)
                    status = ST_BAD;
                else if (cnt_reg == FULL_CNT)
                    status = ST_FULL;
                else
                begin
                    do_ins = 1'b1;
                    if (request.cmd == CMD_INS_END)
                        at_x = cnt_x;
                    else if (request.cmd == CMD_INS_AT)
                        at_x = pos_x;
                end
            end
            CMD_REM_FRONT, CMD_REM_END, CMD_REM_AT:
            begin
                if (cnt_reg == '0)
                    status = ST_EMPTY;
                else if (request.cmd == CMD_REM_AT && pos_x >= cnt_x)
                    status = ST_BAD;
                else
                begin
                    do_rem = 1'b1;
                    if (request.cmd == CMD_REM_END)
                        at_x = cnt_x - PW'(1);
                    else if (request.cmd == CMD_REM_AT)
                        at_x = pos_x;
                end
            end
            CMD_READ:
            begin
                if (pos_x >= cnt_x)
                    status = ST_BAD;
                else
                begin
                    do_rd = 1'b1;
                    at_x  = pos_x;
                end
            end
            default:
                status = ST_BAD;
        endcase
    end

    always_comb
    begin
        shift.ins = accept && do_ins;
        shift.rem = accept && do_rem;
        shift.rd  = do_rd;
        shift.at  = MAX_IDX_W'(at_x);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (shift.ins)
            cnt_next = cnt_reg + CW'(1);
        else if (shift.rem)
            cnt_next = cnt_reg - CW'(1);
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;
        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        plid_cell #(.IDX(i)) u_cell (
            .clk        (clk),
            .shift      (shift),
            .left_data  (left_d),
            .right_data (right_d),
            .new_data   (request.value),
            .data       (cell_data[i]),
            .sel_data   (cell_sel[i])
        );
    end

    // Only the addressed cell drives a nonzero value, so OR picks it out
    for (genvar g = 0; g < NG; g++)
    begin : g_grp
        always_comb
        begin
            grp_or[g] = '0;
            for (int k = 0; k < GS; k++)
            begin
                if (g * GS + k < DEPTH)
                    grp_or[g] = grp_or[g] | cell_sel[g * GS + k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (accept)
                grp_reg[g] <= grp_or[g];
        end
    end

    always_comb
    begin
        gather = '0;
        for (int g = 0; g < NG; g++)
            gather = gather | grp_reg[g];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (move)
                s1_valid_reg <= 1'b0;
            if (move)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status;
            s1_count_reg  <= CNT_W'(cnt_next);
        end
        if (move)
        begin
            out_status_reg <= s1_status_reg;
            out_count_reg  <= s1_count_reg;
            out_value_reg  <= gather;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.status     = out_status_reg;
    assign result.count      = out_count_reg;
    assign result.read_value = out_value_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("list count above depth");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        shift.ins |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("insert did not grow count");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !move |=> s1_valid_reg && $stable(s1_status_reg))
        else $error("stalled request lost in stage 1");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(out_value_reg))
        else $error("waiting result overwritten");

endmodule

`default_nettype wire

FILE: sim/positional_list_insert_delete_core_tb.sv
// Self-checking testbench for positional_list_insert_delete_core.
// Depends on plid_pkg, plid_req_if, plid_rsp_if and the core itself.
// Random stalls on both channels; every result is checked against a predicted list.
module positional_list_insert_delete_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plid_pkg::*;

    localparam int LIST_DEPTH = 256;
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic [2:0]               cmd;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } list_cmd_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] read_value;
    } list_result_t;

    logic clk;
    logic rst_n;

    plid_req_if req_ch();
    plid_rsp_if rsp_ch();

    positional_list_insert_delete_core #(.DEPTH(LIST_DEPTH)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch.sink),
        .result  (rsp_ch.source)
    );

    // predicted list contents
    logic signed [DATA_W-1:0] list_mem [LIST_DEPTH];
    int list_len = 0;

    list_cmd_t    pending_cmds[$];
    list_result_t expected_results[$];

    int gen_len = 0;          // length as seen by the generator
    int requests_taken = 0;
    int results_checked = 0;
    int mismatches = 0;
    int full_seen = 0;
    int empty_seen = 0;
    int hold_left = 0;
    bit hold_done = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic list_result_t apply_command(list_cmd_t c);
        list_result_t r;
        int at;
        int i;
        r.status = ST_OK;
        r.read_value = '0;
        case (c.cmd) inside
            CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT:
            begin
                if (c.cmd == CMD_INS_AT && int'(c.position) > list_len)
                    r.status = ST_BAD;
                else if (list_len >= LIST_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    at = (c.cmd == CMD_INS_FRONT) ? 0 :
                         (c.cmd == CMD_INS_END) ? list_len : int'(c.position);
                    for (i = list_len; i > at; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[at] = c.value;
                    list_len++;
                end
            end
            CMD_REM_FRONT, CMD_REM_END, CMD_REM_AT:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else if (c.cmd == CMD_REM_AT && int'(c.position) >= list_len)
                    r.status = ST_BAD;
                else
                begin
                    at = (c.cmd == CMD_REM_FRONT) ? 0 :
                         (c.cmd == CMD_REM_END) ? list_len - 1 : int'(c.position);
                    for (i = at; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            CMD_READ:
            begin
                if (int'(c.position) >= list_len)
                    r.status = ST_BAD;
                else
                    r.read_value = list_mem[c.position];
            end
            default: r.status = ST_BAD;
        endcase
        r.count = list_len[CNT_W-1:0];
        return r;
    endfunction

    // generator side: tracks the length only, to aim positions
    function automatic void queue_cmd(logic [2:0] c, int p, logic signed [DATA_W-1:0] v);
        list_cmd_t item;
        item.cmd = c;
        item.position = p[POS_W-1:0];
        item.value = v;
        pending_cmds.push_back(item);
        case (c) inside
            CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT:
                if ((c != CMD_INS_AT || p <= gen_len) && gen_len < LIST_DEPTH)
                    gen_len++;
            CMD_REM_FRONT, CMD_REM_END, CMD_REM_AT:
                if (gen_len > 0 && (c != CMD_REM_AT || p < gen_len))
                    gen_len--;
            default: ;
        endcase
    endfunction

    // edges of the legal range come up often
    function automatic int pick_pos(int hi);
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return 0;
        if (r == 1)
            return hi;
        return $urandom_range(0, hi);
    endfunction

    function automatic void random_cmd(int ins_w, int rem_w);
        int r;
        int kind;
        int top;
        logic signed [DATA_W-1:0] v;
        r = $urandom_range(0, 99);
        kind = $urandom_range(0, 2);
        top = (gen_len > 0) ? gen_len - 1 : 0;
        v = $urandom;
        if (r < 6)
            queue_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 511), v);
        else if (r < 6 + ins_w)
            queue_cmd(kind == 0 ? CMD_INS_FRONT : (kind == 1 ? CMD_INS_END : CMD_INS_AT),
                      pick_pos(gen_len), v);
        else if (r < 6 + ins_w + rem_w)
            queue_cmd(kind == 0 ? CMD_REM_FRONT : (kind == 1 ? CMD_REM_END : CMD_REM_AT),
                      pick_pos(top), v);
        else
            queue_cmd(CMD_READ, pick_pos(top), v);
    endfunction

    function automatic bit stall_now(int progress);
        if (progress >= 600 && progress < 800)
            return 1'b0;
        return $urandom_range(0, 99) < 32;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        list_cmd_t item;
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.cmd      <= CMD_READ;
            req_ch.position <= '0;
            req_ch.value    <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (req_ch.valid)
            begin
                item.cmd = req_ch.cmd;
                item.position = req_ch.position;
                item.value = req_ch.value;
                expected_results.push_back(apply_command(item));
                requests_taken <= requests_taken + 1;
            end
            if (pending_cmds.size() != 0 && !stall_now(requests_taken))
            begin
                item = pending_cmds.pop_front();
                req_ch.valid    <= 1'b1;
                req_ch.cmd      <= item.cmd;
                req_ch.position <= item.position;
                req_ch.value    <= item.value;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // one long hold-off on the result side so the core backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_checked >= 300)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : check_results
        list_result_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_checked <= results_checked + 1;
                if (rsp_ch.status == ST_FULL)
                    full_seen <= full_seen + 1;
                if (rsp_ch.status == ST_EMPTY)
                    empty_seen <= empty_seen + 1;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result status=%0d count=%0d read_value=%0d",
                             $time, rsp_ch.status, rsp_ch.count, rsp_ch.read_value);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.count !== want.count ||
                        rsp_ch.read_value !== want.read_value)
                    begin
                        mismatches++;
                        $write("%0t: result %0d mismatch: expected status=%0d count=%0d",
                               $time, results_checked, want.status, want.count);
                        $display(" read_value=%0d, got status=%0d count=%0d read_value=%0d",
                                 want.read_value, rsp_ch.status, rsp_ch.count,
                                 rsp_ch.read_value);
                    end
                end
            end
            rsp_ch.ready <= (hold_left == 0) && !stall_now(results_checked);
        end
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;

        // directed: empty list, value extremes, range edges, every command
        queue_cmd(CMD_READ, 0, 0);
        queue_cmd(CMD_REM_FRONT, 0, 0);
        queue_cmd(CMD_REM_END, 0, 0);
        queue_cmd(CMD_REM_AT, 0, 0);
        queue_cmd(CMD_INS_AT, 1, 5);
        queue_cmd(CMD_INS_AT, 0, 32'sh8000_0000);
        queue_cmd(CMD_INS_END, 0, 32'sh7fff_ffff);
        queue_cmd(CMD_INS_FRONT, 0, 0);
        queue_cmd(CMD_INS_AT, 2, -1);
        queue_cmd(CMD_INS_AT, 4, 32'sh5a5a_5a5a);
        queue_cmd(CMD_READ, 0, 0);
        queue_cmd(CMD_READ, 4, 0);
        queue_cmd(CMD_READ, 5, 0);
        queue_cmd(CMD_READ, 256, 0);
        queue_cmd(CMD_READ, 511, -1);
        queue_cmd(CMD_UNUSED, 511, -1);
        queue_cmd(CMD_REM_AT, 5, 0);
        queue_cmd(CMD_REM_AT, 511, 0);
        queue_cmd(CMD_REM_AT, 2, 0);
        queue_cmd(CMD_REM_FRONT, 0, 0);
        queue_cmd(CMD_REM_END, 0, 0);
        queue_cmd(CMD_READ, 0, 0);
        queue_cmd(CMD_REM_AT, 1, 0);
        queue_cmd(CMD_REM_END, 0, 0);

        // fill to capacity, hammer the full list, drain, then wander
        while (gen_len < LIST_DEPTH)
            random_cmd(70, 14);
        queue_cmd(CMD_INS_FRONT, 0, 1);
        queue_cmd(CMD_INS_END, 0, 2);
        queue_cmd(CMD_INS_AT, 256, 3);
        queue_cmd(CMD_INS_AT, 257, 4);
        queue_cmd(CMD_INS_AT, 511, 5);
        queue_cmd(CMD_READ, 255, 0);
        queue_cmd(CMD_READ, 256, 0);
        queue_cmd(CMD_REM_AT, 256, 0);
        queue_cmd(CMD_REM_AT, 255, 0);
        queue_cmd(CMD_INS_AT, 255, $urandom);
        queue_cmd(CMD_INS_END, 0, 6);
        while (gen_len > 0)
            random_cmd(14, 70);
        while (pending_cmds.size() < 1550)
            random_cmd(35, 35);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        // two-stage pipeline; an idle wait catches stray results
        repeat (20) @(posedge clk);

        $display("Ran %0d list commands and checked %0d results.",
                 requests_taken, results_checked);
        $display("Full-list refusals: %0d, empty-list refusals: %0d, one %0d-cycle output hold.",
                 full_seen, empty_seen, HOLD_CYCLES);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
